[rtl/core/mexp_pkg.sv]
package mexp_pkg;

  // Width of the modulus and of every reduced value.
  localparam int W = 31;
  localparam int MCNT_W = $clog2(W + 1);
  localparam int EXP_BITS_DEF = 63;
  localparam int EXP_PORT_W = 63;
  localparam logic [W-1:0] MOD_RESET = 31'd1000000007;

  localparam logic OP_POWER = 1'b0;
  localparam logic OP_DIVIDE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_BASE,
    ST_RED_DIV,
    ST_SCAN,
    ST_SQR,
    ST_MUL,
    ST_FIN,
    ST_OUT
  } state_t;

  // Operand selection for the shared modular multiplier.
  typedef enum logic [2:0] {
    MM_RED_BASE,
    MM_RED_DIV,
    MM_SQR,
    MM_MUL,
    MM_FIN
  } mm_sel_t;

  typedef struct packed {
    logic    load_in;
    logic    mm_start;
    mm_sel_t mm_sel;
    logic    wr_base;
    logic    wr_div;
    logic    wr_acc;
    logic    acc_from_base;
    logic    load_e;
    logic    shift_exp;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic m_zero;
    logic opcode;
    logic exp_msb;
    logic cnt_zero;
    logic mm_done;
    logic out_free;
  } dp_stat_t;

endpackage

[rtl/core/mexp_modmul.sv]
module mexp_modmul (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [mexp_pkg::W-1:0] x,
  input  logic [mexp_pkg::W-1:0] y,
  input  logic [mexp_pkg::W-1:0] m,
  output logic                  done,
  output logic [mexp_pkg::W-1:0] res
);

  localparam int W = mexp_pkg::W;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [mexp_pkg::MCNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]      x_r, x_nxt;
  logic [W-1:0]      y_r, y_nxt;
  logic [W-1:0]      p_r, p_nxt;
  logic [W+1:0]      t, t_m, t_2m, m_ext, m2_ext;

  // Interleaved multiply: one bit of x per cycle, MSB first, with the
  // partial product kept below m. 2p + y < 3m, so at most 2m is removed.
  always_comb begin
    m_ext  = {2'b00, m};
    m2_ext = {1'b0, m, 1'b0};
    t      = {1'b0, p_r, 1'b0} + (x_r[W-1] ? {2'b00, y_r} : '0);
    t_m    = t - m_ext;
    t_2m   = t - m2_ext;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    p_nxt    = p_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = mexp_pkg::MCNT_W'(W);
      x_nxt    = x;
      y_nxt    = y;
      p_nxt    = '0;
    end else if (busy_r) begin
      x_nxt = {x_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (t >= m2_ext) begin
        p_nxt = t_2m[W-1:0];
      end else if (t >= m_ext) begin
        p_nxt = t_m[W-1:0];
      end else begin
        p_nxt = t[W-1:0];
      end
      if (cnt_r == mexp_pkg::MCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    p_r   <= p_nxt;
  end

  assign done = done_r;
  assign res  = p_r;

endmodule

[rtl/core/mexp_datapath.sv]
module mexp_datapath #(
  parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [mexp_pkg::W-1:0]          cfg_wr_data,
  input  logic                            in_opcode,
  input  logic [mexp_pkg::W-1:0]          in_base,
  input  logic [mexp_pkg::EXP_PORT_W-1:0] in_exponent,
  input  logic [mexp_pkg::W-1:0]          in_dividend,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mexp_pkg::W-1:0]          out_result,
  input  mexp_pkg::ctrl_cmd_t             cmd,
  output mexp_pkg::dp_stat_t              stat
);

  localparam int W = mexp_pkg::W;
  localparam int EW = (EXP_BITS > W) ? EXP_BITS : W;
  localparam int CNT_W = $clog2(EW + 1);
  // Only the low EXP_BITS bits of any exponent take part, the Fermat one too.
  localparam int FW = (EXP_BITS < W) ? EXP_BITS : W;

  logic [W-1:0]     m_r, m_nxt;
  logic             opcode_r, opcode_nxt;
  logic [W-1:0]     base_r, base_nxt;
  logic [W-1:0]     div_r, div_nxt;
  logic [W-1:0]     acc_r, acc_nxt;
  logic [EW-1:0]    exp_r, exp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [W-1:0]     out_result_r, out_result_nxt;

  logic             m_le1;
  logic [W-1:0]     fermat_e;
  logic [W-1:0]     mm_x, mm_y, mm_res;
  logic             mm_done;

  assign m_le1    = (m_r[W-1:1] == '0);
  assign fermat_e = m_le1 ? '0 : (m_r - W'(2));

  always_comb begin
    unique case (cmd.mm_sel)
      mexp_pkg::MM_RED_BASE: begin
        mm_x = in_base;
        mm_y = W'(1);
      end
      mexp_pkg::MM_RED_DIV: begin
        mm_x = div_r;
        mm_y = W'(1);
      end
      mexp_pkg::MM_SQR: begin
        mm_x = acc_r;
        mm_y = acc_r;
      end
      mexp_pkg::MM_MUL: begin
        mm_x = mm_res;
        mm_y = base_r;
      end
      mexp_pkg::MM_FIN: begin
        mm_x = div_r;
        mm_y = acc_r;
      end
      default: begin
        mm_x = acc_r;
        mm_y = acc_r;
      end
    endcase
  end

  mexp_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mm_start),
    .x     (mm_x),
    .y     (mm_y),
    .m     (m_r),
    .done  (mm_done),
    .res   (mm_res)
  );

  always_comb begin
    m_nxt          = cfg_wr_en ? cfg_wr_data : m_r;
    opcode_nxt     = cmd.load_in ? in_opcode : opcode_r;
    base_nxt       = cmd.wr_base ? mm_res : base_r;
    div_nxt        = div_r;
    acc_nxt        = acc_r;
    exp_nxt        = exp_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r;
    out_result_nxt = out_result_r;

    priority if (cmd.load_in) begin
      div_nxt = in_dividend;
    end else if (cmd.wr_div) begin
      div_nxt = mm_res;
    end else begin
      div_nxt = div_r;
    end

    // The accumulator starts at one reduced by m, which is zero for m of zero or one.
    priority if (cmd.load_in) begin
      acc_nxt = m_le1 ? '0 : W'(1);
    end else if (cmd.acc_from_base) begin
      acc_nxt = base_r;
    end else if (cmd.wr_acc) begin
      acc_nxt = mm_res;
    end else begin
      acc_nxt = acc_r;
    end

    // Exponent bits are left aligned so the scan always reads the top bit.
    priority if (cmd.load_in) begin
      exp_nxt = EW'(in_exponent[EXP_BITS-1:0]) << (EW - EXP_BITS);
      cnt_nxt = CNT_W'(EXP_BITS);
    end else if (cmd.load_e) begin
      exp_nxt = EW'(fermat_e[FW-1:0]) << (EW - FW);
      cnt_nxt = CNT_W'(FW);
    end else if (cmd.shift_exp) begin
      exp_nxt = {exp_r[EW-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
    end else begin
      exp_nxt = exp_r;
      cnt_nxt = cnt_r;
    end

    if (cmd.out_load) begin
      out_valid_nxt  = 1'b1;
      out_result_nxt = acc_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r         <= mexp_pkg::MOD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      m_r         <= m_nxt;
      out_valid_r <= out_valid_nxt;
    end
    opcode_r     <= opcode_nxt;
    base_r       <= base_nxt;
    div_r        <= div_nxt;
    acc_r        <= acc_nxt;
    exp_r        <= exp_nxt;
    cnt_r        <= cnt_nxt;
    out_result_r <= out_result_nxt;
  end

  assign stat.m_zero   = (m_r == '0);
  assign stat.opcode   = opcode_r;
  assign stat.exp_msb  = exp_r[EW-1];
  assign stat.cnt_zero = (cnt_r == '0);
  assign stat.mm_done  = mm_done;
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

[rtl/core/mexp_ctrl.sv]
module mexp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mexp_pkg::dp_stat_t   stat,
  output mexp_pkg::ctrl_cmd_t  cmd,
  output mexp_pkg::state_t     state
);

  mexp_pkg::state_t state_r, state_nxt;
  logic             started_r, started_nxt;

  always_comb begin
    state_nxt   = state_r;
    started_nxt = started_r;
    unique case (state_r)
      mexp_pkg::ST_IDLE: begin
        if (in_valid) begin
          started_nxt = 1'b0;
          state_nxt   = stat.m_zero ? mexp_pkg::ST_OUT : mexp_pkg::ST_RED_BASE;
        end
      end
      mexp_pkg::ST_RED_BASE: begin
        if (stat.mm_done) begin
          state_nxt = (stat.opcode == mexp_pkg::OP_DIVIDE) ? mexp_pkg::ST_RED_DIV
                                                           : mexp_pkg::ST_SCAN;
        end
      end
      mexp_pkg::ST_RED_DIV: begin
        if (stat.mm_done) begin
          state_nxt = mexp_pkg::ST_SCAN;
        end
      end
      mexp_pkg::ST_SCAN: begin
        if (stat.cnt_zero) begin
          state_nxt = (stat.opcode == mexp_pkg::OP_DIVIDE) ? mexp_pkg::ST_FIN
                                                           : mexp_pkg::ST_OUT;
        end else if (!started_r) begin
          if (stat.exp_msb) begin
            started_nxt = 1'b1;
          end
        end else begin
          state_nxt = mexp_pkg::ST_SQR;
        end
      end
      mexp_pkg::ST_SQR: begin
        if (stat.mm_done) begin
          state_nxt = stat.exp_msb ? mexp_pkg::ST_MUL : mexp_pkg::ST_SCAN;
        end
      end
      mexp_pkg::ST_MUL: begin
        if (stat.mm_done) begin
          state_nxt = mexp_pkg::ST_SCAN;
        end
      end
      mexp_pkg::ST_FIN: begin
        if (stat.mm_done) begin
          state_nxt = mexp_pkg::ST_OUT;
        end
      end
      mexp_pkg::ST_OUT: begin
        if (stat.out_free) begin
          state_nxt = mexp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mexp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mm_sel = mexp_pkg::MM_SQR;
    unique case (state_r)
      mexp_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (!stat.m_zero) begin
            cmd.mm_start = 1'b1;
            cmd.mm_sel   = mexp_pkg::MM_RED_BASE;
          end
        end
      end
      mexp_pkg::ST_RED_BASE: begin
        if (stat.mm_done) begin
          cmd.wr_base = 1'b1;
          if (stat.opcode == mexp_pkg::OP_DIVIDE) begin
            cmd.mm_start = 1'b1;
            cmd.mm_sel   = mexp_pkg::MM_RED_DIV;
          end
        end
      end
      mexp_pkg::ST_RED_DIV: begin
        if (stat.mm_done) begin
          cmd.wr_div = 1'b1;
          cmd.load_e = 1'b1;
        end
      end
      mexp_pkg::ST_SCAN: begin
        if (stat.cnt_zero) begin
          if (stat.opcode == mexp_pkg::OP_DIVIDE) begin
            cmd.mm_start = 1'b1;
            cmd.mm_sel   = mexp_pkg::MM_FIN;
          end
        end else if (!started_r) begin
          // Leading zero bits only square a one, so they are skipped.
          cmd.shift_exp     = 1'b1;
          cmd.acc_from_base = stat.exp_msb;
        end else begin
          cmd.mm_start = 1'b1;
          cmd.mm_sel   = mexp_pkg::MM_SQR;
        end
      end
      mexp_pkg::ST_SQR: begin
        if (stat.mm_done) begin
          cmd.wr_acc    = 1'b1;
          cmd.shift_exp = 1'b1;
          if (stat.exp_msb) begin
            cmd.mm_start = 1'b1;
            cmd.mm_sel   = mexp_pkg::MM_MUL;
          end
        end
      end
      mexp_pkg::ST_MUL, mexp_pkg::ST_FIN: begin
        cmd.wr_acc = stat.mm_done;
      end
      mexp_pkg::ST_OUT: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        cmd.load_in = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mexp_pkg::ST_IDLE;
      started_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      started_r <= started_nxt;
    end
  end

  assign in_stall = (state_r != mexp_pkg::ST_IDLE);
  assign state    = state_r;

endmodule

[rtl/core/modular_exponentiation_core.sv]
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   in_opcode, in_base, in_exponent, in_dividend
// out       output     out_valid/out_stall out_result
// cfg       input      cfg_wr_en           cfg_wr_data (modulus)
//
// Every modular multiply runs in one shared bit-serial unit. A power scans
// the exponent from its top set bit. A division reduces both operands, scans
// the 31 bits of the modulus minus two and ends with one multiply. Reset is
// synchronous, active low, and loads 1000000007; a stalled result waits while
// the next transaction runs.
module modular_exponentiation_core #(
  parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [mexp_pkg::W-1:0]          cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_opcode,
  input  logic [mexp_pkg::W-1:0]          in_base,
  input  logic [mexp_pkg::EXP_PORT_W-1:0] in_exponent,
  input  logic [mexp_pkg::W-1:0]          in_dividend,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mexp_pkg::W-1:0]          out_result
);

  mexp_pkg::ctrl_cmd_t cmd;
  mexp_pkg::dp_stat_t  stat;
  mexp_pkg::state_t    state;

  mexp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd),
    .state    (state)
  );

  mexp_datapath #(
    .EXP_BITS (EXP_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_opcode   (in_opcode),
    .in_base     (in_base),
    .in_exponent (in_exponent),
    .in_dividend (in_dividend),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_result  (out_result),
    .cmd         (cmd),
    .stat        (stat)
  );

  // An accepted transaction always takes the controller out of idle.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state != mexp_pkg::ST_IDLE))
    else $error("accepted transaction did not leave idle");

  // A new result appears only when the controller hands one over.
  a_result_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state == mexp_pkg::ST_OUT))
    else $error("result appeared outside the hand-over state");

  // The multiplier is never restarted in the cycle after a start.
  a_no_back_to_back_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mm_start |=> !cmd.mm_start)
    else $error("multiplier started on consecutive cycles");

endmodule
